[src/prmq_pkg.sv]
package prmq_pkg;

    typedef enum logic [1:0] {
        ST_PUSHED   = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    localparam logic [0:0] REG_UPDATE_MODE = 1'b0;
    localparam logic [0:0] REG_TRANS_IN_USE = 1'b1;

    localparam logic [31:0] INIT_POTENCY = 32'd100;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ADJUST,
        S_BUB_READ,
        S_BUB_SWAP,
        S_STORE,
        S_WALK,
        S_SCAN_START,
        S_SCAN,
        S_SCAN_LAST,
        S_POP_FETCH,
        S_POP_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic check;
        logic adjust;
        logic bub_read;
        logic bub_swap;
        logic store;
        logic walk_start;
        logic walk_step;
        logic scan_start;
        logic scan_step;
        logic scan_last;
        logic pop_fetch;
        logic pop_move;
        logic load_result;
        logic [1:0] result_status;
    } ctrl_t;

    typedef struct packed {
        logic is_pop;
        logic reject;
        logic rising;
        logic changed;
        logic bub_go;
        logic walk_found;
        logic walk_fail;
        logic empty_all;
        logic scan_more;
    } stat_t;

endpackage

[src/prmq_if.sv]
interface prmq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] item_id;
    logic [31:0] distance;
    logic [3:0]  transition;
    logic [31:0] parent_distance;
    modport source (output valid, kind, item_id, distance, transition, parent_distance,
                    input ready);
    modport sink (input valid, kind, item_id, distance, transition, parent_distance,
                  output ready);
endinterface

interface prmq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_item;
    logic [31:0] out_weight;
    modport source (output valid, status, out_item, out_weight, input ready);
    modport sink (input valid, status, out_item, out_weight, output ready);
endinterface

interface prmq_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [4:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/prmq_ctrl.sv]
module prmq_ctrl
    import prmq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  res_valid,
    input  logic  res_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic res_valid_reg, res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        ctrl.result_status = ST_PUSHED;
        res_valid_next = res_valid_reg && !res_ready;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.latch_in = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl.check = 1'b1;
                if (stat.is_pop)
                begin
                    if (stat.empty_all)
                    begin
                        ctrl.result_status = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctrl.walk_start = 1'b1;
                        state_next = S_WALK;
                    end
                end
                else if (stat.reject)
                begin
                    ctrl.result_status = ST_REJECTED;
                    state_next = S_DONE;
                end
                else
                    state_next = S_ADJUST;
            end
            S_ADJUST:
            begin
                ctrl.adjust = 1'b1;
                state_next = stat.changed ? S_BUB_READ : S_STORE;
            end
            S_BUB_READ:
            begin
                ctrl.bub_read = 1'b1;
                state_next = stat.bub_go ? S_BUB_SWAP : S_STORE;
            end
            S_BUB_SWAP:
            begin
                ctrl.bub_swap = 1'b1;
                state_next = S_BUB_READ;
            end
            S_STORE:
            begin
                ctrl.store = 1'b1;
                ctrl.result_status = ST_PUSHED;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                ctrl.walk_step = 1'b1;
                if (stat.walk_found)
                    state_next = S_SCAN_START;
                else if (stat.walk_fail)
                begin
                    ctrl.result_status = ST_EMPTY;
                    state_next = S_DONE;
                end
            end
            S_SCAN_START:
            begin
                ctrl.scan_start = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (!stat.scan_more)
                    state_next = S_SCAN_LAST;
            end
            S_SCAN_LAST:
            begin
                ctrl.scan_last = 1'b1;
                state_next = S_POP_FETCH;
            end
            S_POP_FETCH:
            begin
                ctrl.pop_fetch = 1'b1;
                state_next = S_POP_MOVE;
            end
            S_POP_MOVE:
            begin
                ctrl.pop_move = 1'b1;
                ctrl.result_status = ST_POPPED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    ctrl.load_result = 1'b1;
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg != S_DONE)
        begin
            case (state_next)
                S_DONE:
                    ctrl.load_result = 1'b0;
                default:
                    ctrl.load_result = 1'b0;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> res_valid_reg)
        else $error("result not raised");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUB_SWAP) |=> state_reg == S_BUB_READ)
        else $error("swap sequence");

endmodule

[src/prmq_dp.sv]
module prmq_dp
    import prmq_pkg::*;
#(
    parameter int NUM_TRANSITIONS = 16,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    output stat_t       stat,
    input  logic        in_kind,
    input  logic [31:0] in_item_id,
    input  logic [31:0] in_distance,
    input  logic [3:0]  in_transition,
    input  logic [31:0] in_parent_distance,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output logic [1:0]  res_status,
    output logic [31:0] res_item,
    output logic [31:0] res_weight
);

    localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
    localparam int LW = $clog2(NUM_TRANSITIONS + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(NUM_TRANSITIONS * QUEUE_DEPTH + 1);
    localparam int MW = TW + QW;
    localparam int MD = NUM_TRANSITIONS << QW;
    localparam logic [LW-1:0] NO_LINK = LW'(NUM_TRANSITIONS);
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    logic        mode_reg;
    logic [4:0]  in_use_reg;
    logic [31:0] potency_reg [NUM_TRANSITIONS];
    logic [LW-1:0] prev_reg [NUM_TRANSITIONS];
    logic [LW-1:0] next_reg [NUM_TRANSITIONS];
    logic [FW-1:0] fill_reg [NUM_TRANSITIONS];
    logic [TW-1:0] head_reg;
    logic [CW-1:0] total_reg;

    logic        kind_reg;
    logic [31:0] id_reg, dist_reg, pdist_reg;
    logic [TW-1:0] t_reg;
    logic [3:0]  tr_reg;
    logic        up_reg;
    logic [31:0] nb_pot;
    logic [LW-1:0] nb_reg;
    logic        nb_ok;
    logic [LW-1:0] walk_reg;
    logic [LW-1:0] steps_reg;
    logic [QW-1:0] k_reg, best_reg;
    logic [QW-1:0] k_prev;
    logic [63:0] best_val_reg;
    logic [63:0] rd_reg;
    logic [1:0]  st_reg;
    logic [31:0] item_reg, weight_reg;

    logic [63:0] mem [MD];
    logic [MW-1:0] rd_addr;
    logic [FW-1:0] fill_t;
    logic [TW-1:0] walk_t;
    logic [LW-1:0] t_link;

    assign fill_t = fill_reg[t_reg];
    assign walk_t = walk_reg[TW-1:0];
    assign t_link = LW'(t_reg);
    assign k_prev = k_reg - QW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            in_use_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UPDATE_MODE: mode_reg <= cfg_data[0];
                REG_TRANS_IN_USE: in_use_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [5:0] limit;
    assign limit = (in_use_reg > 5'(NUM_TRANSITIONS > 31 ? 31 : NUM_TRANSITIONS)
                    && NUM_TRANSITIONS < 32) ? 6'(NUM_TRANSITIONS) : {1'b0, in_use_reg};

    logic [31:0] diff_up, diff_dn, pot_t;
    logic [32:0] sum_up;
    assign pot_t = potency_reg[t_reg];
    assign diff_up = mode_reg ? (pdist_reg - dist_reg) : 32'd1;
    assign diff_dn = mode_reg ? (dist_reg - pdist_reg) : 32'd1;
    assign sum_up = {1'b0, pot_t} + {1'b0, diff_up};

    assign stat.is_pop = kind_reg;
    assign stat.reject = ({2'b0, tr_reg} >= limit) || (fill_t >= FW'(QUEUE_DEPTH));
    assign stat.rising = up_reg;
    assign stat.changed = (dist_reg < pdist_reg) || (dist_reg > pdist_reg && pot_t != 0);
    assign stat.empty_all = (total_reg == '0);
    assign stat.walk_found = (walk_reg < NO_LINK) && (fill_reg[walk_t] != '0);
    assign stat.walk_fail = !(walk_reg < NO_LINK) || (steps_reg >= NO_LINK);
    assign stat.scan_more = (FW'(k_reg) + FW'(1)) < fill_t;

    logic [TW-1:0] nb_t;
    assign nb_t = nb_reg[TW-1:0];
    assign stat.bub_go = nb_ok &&
                         (up_reg ? (pot_t > nb_pot) : (pot_t < nb_pot));

    always_comb
    begin
        rd_addr = {t_reg, k_reg};
        if (ctrl.scan_start)
            rd_addr = {t_reg, {QW{1'b0}}};
        if (ctrl.pop_fetch)
            rd_addr = {t_reg, QW'(fill_t - FW'(1))};
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (ctrl.store)
            mem[{t_reg, fill_t[QW-1:0]}] <= {dist_reg, id_reg};
        if (ctrl.pop_move)
            mem[{t_reg, best_reg}] <= rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            kind_reg <= in_kind;
            id_reg <= in_item_id;
            dist_reg <= in_distance;
            pdist_reg <= in_parent_distance;
            t_reg <= TW'(in_transition);
            tr_reg <= in_transition;
        end
        if (ctrl.walk_step && stat.walk_found)
            t_reg <= walk_t;
        if (ctrl.adjust)
            up_reg <= dist_reg < pdist_reg;
        if (ctrl.adjust)
            nb_reg <= (dist_reg < pdist_reg) ? prev_reg[t_reg] : next_reg[t_reg];
        if (ctrl.bub_swap)
            nb_reg <= up_reg ? prev_reg[nb_t] : next_reg[nb_t];
        if (ctrl.scan_start)
        begin
            k_reg <= QW'(1);
            best_reg <= '0;
        end
        if (ctrl.scan_start)
            best_val_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
        if (ctrl.scan_step || (ctrl.scan_last && FW'(k_prev) < fill_t))
        begin
            if (rd_reg < best_val_reg)
            begin
                best_val_reg <= rd_reg;
                best_reg <= k_prev;
            end
        end
        if (ctrl.scan_step || ctrl.scan_last)
            k_reg <= k_reg + QW'(1);
        if (ctrl.check)
            st_reg <= ctrl.result_status;
        if (ctrl.walk_step)
            st_reg <= ctrl.result_status;
        if (ctrl.store || ctrl.pop_move)
            st_reg <= ctrl.result_status;
        if (ctrl.pop_move)
        begin
            item_reg <= best_val_reg[31:0];
            weight_reg <= best_val_reg[63:32];
        end
        if (ctrl.latch_in)
        begin
            item_reg <= '0;
            weight_reg <= '0;
        end
    end

    // scan: k_reg addresses entry k; the registered rd_reg holds entry k-1.
    // neighbor potency read straight from the array
    assign nb_pot = potency_reg[nb_t];
    assign nb_ok = (nb_reg != NO_LINK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TRANSITIONS; i++)
            begin
                potency_reg[i] <= INIT_POTENCY;
                prev_reg[i] <= (i == 0) ? NO_LINK : LW'(i - 1);
                next_reg[i] <= (i == NUM_TRANSITIONS - 1) ? NO_LINK : LW'(i + 1);
                fill_reg[i] <= '0;
            end
            head_reg <= '0;
            total_reg <= '0;
            walk_reg <= '0;
            steps_reg <= '0;
        end
        else
        begin
            if (ctrl.adjust)
            begin
                if (dist_reg < pdist_reg)
                    potency_reg[t_reg] <= sum_up[32] ? MAX32 : sum_up[31:0];
                else if (dist_reg > pdist_reg && pot_t != 0)
                    potency_reg[t_reg] <= (pot_t >= diff_dn) ? pot_t - diff_dn : '0;
            end
            if (ctrl.bub_read && up_reg && !stat.bub_go)
            begin
                if (prev_reg[t_reg] == NO_LINK)
                    head_reg <= t_reg;
            end
            if (ctrl.bub_swap)
            begin
                if (up_reg)
                begin
                    // a = nb, b = t
                    if (prev_reg[nb_t] != NO_LINK)
                        next_reg[prev_reg[nb_t][TW-1:0]] <= t_link;
                    if (next_reg[t_reg] != NO_LINK)
                        prev_reg[next_reg[t_reg][TW-1:0]] <= nb_reg;
                    prev_reg[nb_t] <= t_link;
                    next_reg[nb_t] <= next_reg[t_reg];
                    prev_reg[t_reg] <= prev_reg[nb_t];
                    next_reg[t_reg] <= nb_reg;
                end
                else
                begin
                    if (head_reg == t_reg)
                        head_reg <= nb_t;
                    if (prev_reg[t_reg] != NO_LINK)
                        next_reg[prev_reg[t_reg][TW-1:0]] <= nb_reg;
                    if (next_reg[nb_t] != NO_LINK)
                        prev_reg[next_reg[nb_t][TW-1:0]] <= t_link;
                    prev_reg[t_reg] <= nb_reg;
                    next_reg[t_reg] <= next_reg[nb_t];
                    prev_reg[nb_t] <= prev_reg[t_reg];
                    next_reg[nb_t] <= t_link;
                end
            end
            if (ctrl.store)
            begin
                fill_reg[t_reg] <= fill_t + FW'(1);
                total_reg <= total_reg + CW'(1);
            end
            if (ctrl.walk_start)
            begin
                walk_reg <= LW'(head_reg);
                steps_reg <= '0;
            end
            if (ctrl.walk_step && !stat.walk_found)
            begin
                walk_reg <= next_reg[walk_t];
                steps_reg <= steps_reg + LW'(1);
            end
            if (ctrl.pop_move)
            begin
                fill_reg[t_reg] <= fill_t - FW'(1);
                total_reg <= total_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_result)
        begin
            res_status <= st_reg;
            res_item <= item_reg;
            res_weight <= weight_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.store |=> total_reg == $past(total_reg) + CW'(1))
        else $error("count update");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop_move |-> fill_t != '0)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.store |-> fill_t < FW'(QUEUE_DEPTH))
        else $error("store into full queue");

endmodule

[src/potency_ranked_multi_queue_unit.sv]
// channel | dir  | payload
// in_ch   | sink | kind, item_id, distance, transition, parent_distance
// out_ch  | src  | status, out_item, out_weight
// cfg_ch  | sink | index (0 update_mode, 1 transitions_in_use), data
// Push: check, potency adjust, list moves (none with equal distances, at most
// NUM_TRANSITIONS-1 positions), store; a rejected push or an empty pop skips to the result.
// Pop: walk the list past empty queues, scan the chosen queue for its smallest
// entry (one memory read per cycle), then move its last entry into that slot.
// Reset empties queues, links lists by index, sets potencies; no clearing pass.
// Next transfer is taken while a result waits in the output register.
module potency_ranked_multi_queue_unit
    import prmq_pkg::*;
#(
    parameter int NUM_TRANSITIONS = 16,
    parameter int QUEUE_DEPTH = 16
)
(
    input logic clk,
    input logic rst_n,
    prmq_in_if.sink    in_ch,
    prmq_out_if.source out_ch,
    prmq_cfg_if.sink   cfg_ch
);

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ch.ready = 1'b1;

    prmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .res_valid (out_ch.valid),
        .res_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    prmq_dp #(
        .NUM_TRANSITIONS (NUM_TRANSITIONS),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .stat               (stat),
        .in_kind            (in_ch.kind),
        .in_item_id         (in_ch.item_id),
        .in_distance        (in_ch.distance),
        .in_transition      (in_ch.transition),
        .in_parent_distance (in_ch.parent_distance),
        .cfg_we             (cfg_ch.valid),
        .cfg_index          (cfg_ch.index),
        .cfg_data           (cfg_ch.data),
        .res_status         (out_ch.status),
        .res_item           (out_ch.out_item),
        .res_weight         (out_ch.out_weight)
    );

endmodule
